>>> hdl/sparse_matrix_hash_store_macros.svh
// assertion macros for the sparse matrix hash store
// expects clk and arst_n in the scope of each use
`ifndef SPARSE_MATRIX_HASH_STORE_MACROS_SVH
`define SPARSE_MATRIX_HASH_STORE_MACROS_SVH
`ifndef SYNTH
`define SMHS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("smhs assertion failed");
`define SMHS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("smhs forbidden condition");
`else
`define SMHS_ASSERT(lbl, prop)
`define SMHS_NEVER(lbl, expr)
`endif
`endif

>>> hdl/smhs_pkg.sv
// types, codes and sizes of the sparse matrix hash store
// no dependencies; slot counts are powers of two
`default_nettype none
package smhs_pkg;
	localparam int ROW_SLOTS = 64;
	localparam int COL_SLOTS = 64;
	localparam int MAX_PAIRS = 64;
	localparam int ROW_AW = $clog2(ROW_SLOTS);
	localparam int COL_AW = $clog2(COL_SLOTS);
	localparam int MEM_AW = ROW_AW + COL_AW;
	localparam int MEM_DEPTH = ROW_SLOTS * COL_SLOTS;
	localparam int CNT_W = $clog2(COL_SLOTS + 2);
	localparam int ROWS_W = $clog2(ROW_SLOTS + 1);
	localparam int ROW_LIM = (ROW_SLOTS * 3 + 3) / 4;
	localparam int BANK_LIM = COL_SLOTS / 2;
	localparam int LIM_W = 7;

	localparam logic [2:0] MODE_GET = 3'd0;
	localparam logic [2:0] MODE_SET = 3'd1;
	localparam logic [2:0] MODE_ADD = 3'd2;
	localparam logic [2:0] MODE_SUB = 3'd3;
	localparam logic [2:0] MODE_CNT = 3'd4;
	localparam logic [2:0] MODE_DUMP = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ROW_FULL = 2'd1;
	localparam logic [1:0] ST_BANK_FULL = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic [31:0] row_key;
		logic [31:0] col_key;
		logic [31:0] operand;
		logic [6:0] pair_limit;
	} cmd_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [31:0] result_key;
		logic [6:0] entry_count;
		logic [1:0] status;
		logic last;
	} result_t;

	typedef struct packed {
		logic [31:0] key;
		logic [CNT_W-1:0] cnt;
	} row_word_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] val;
	} col_word_t;

	typedef struct packed {
		logic we;
		logic [ROW_AW-1:0] addr;
		row_word_t wdata;
	} row_req_t;

	typedef struct packed {
		logic we;
		logic [MEM_AW-1:0] addr;
		col_word_t wdata;
	} col_req_t;
endpackage
`default_nettype wire

>>> hdl/smhs_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none
module smhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> hdl/smhs_ctrl.sv
// probe sequencer: row and column probing, updates, dump and clearing pass
// depends on smhs_pkg and the assertion macro header
`default_nettype none
`include "sparse_matrix_hash_store_macros.svh"
module smhs_ctrl import smhs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire cmd_t cmd,
	output logic busy,
	output logic strobe,
	output result_t result,
	output row_req_t row_req,
	input wire row_word_t row_rdata,
	output col_req_t col_req,
	input wire col_word_t col_rdata
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_RP_RD = 4'd2;
	localparam logic [3:0] S_RP_CHK = 4'd3;
	localparam logic [3:0] S_CP_RD = 4'd4;
	localparam logic [3:0] S_CP_CHK = 4'd5;
	localparam logic [3:0] S_DP_RD = 4'd6;
	localparam logic [3:0] S_DP_CHK = 4'd7;
	localparam logic [3:0] S_FLUSH = 4'd8;

	logic [3:0] state_q;
	cmd_t cmd_q;
	logic [MEM_AW-1:0] clr_q;
	logic [ROW_SLOTS-1:0] used_q;
	logic [ROWS_W-1:0] rows_q;
	logic [ROW_AW-1:0] rpos_q, rn_q, row_q;
	logic [COL_AW-1:0] cpos_q, cn_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LIM_W-1:0] lim_q, num_q;
	logic pend_v_q;
	col_word_t pend_q;
	logic strobe_q;
	result_t result_q;

	logic is_write, is_get, row_hit, slot_hit, key_match, bank_full;
	logic [31:0] base, newval;
	logic [ROW_AW-1:0] rpos_nx;
	logic [COL_AW-1:0] cpos_nx;
	logic [LIM_W-1:0] num_nx;

	function automatic result_t pack_word(input logic [31:0] val, input logic [31:0] key,
		input logic [6:0] cnt, input logic [1:0] st, input logic lst);
		return '{result_value: val, result_key: key, entry_count: cnt, status: st,
			last: lst};
	endfunction

	assign is_write = cmd_q.mode == MODE_SET || cmd_q.mode == MODE_ADD ||
		cmd_q.mode == MODE_SUB;
	assign is_get = cmd_q.mode == MODE_GET;
	assign row_hit = row_rdata.key == cmd_q.row_key;
	assign key_match = col_rdata.key == cmd_q.col_key;
	assign slot_hit = key_match || col_rdata == '0;
	assign bank_full = !key_match && cnt_q > CNT_W'(BANK_LIM);
	assign base = key_match ? col_rdata.val : 32'd0;
	assign rpos_nx = (rpos_q == ROW_AW'(ROW_SLOTS - 1)) ? '0 : rpos_q + 1'b1;
	assign cpos_nx = (cpos_q == COL_AW'(COL_SLOTS - 1)) ? '0 : cpos_q + 1'b1;
	assign num_nx = num_q + 1'b1;

	always_comb begin
		case (cmd_q.mode)
			MODE_SET: newval = cmd_q.operand;
			MODE_ADD: newval = base + cmd_q.operand;
			default: newval = base - cmd_q.operand;
		endcase
	end

	always_comb begin
		row_req = '0;
		row_req.addr = rpos_q;
		col_req = '0;
		case (state_q)
			S_CLEAR: begin
				col_req.we = 1'b1;
				col_req.addr = clr_q;
			end
			S_RP_RD: begin
				row_req.we = !used_q[rpos_q] && is_write && rows_q < ROWS_W'(ROW_LIM);
				row_req.wdata.key = cmd_q.row_key;
			end
			S_CP_RD, S_CP_CHK: begin
				col_req.addr = {row_q, cpos_q};
				if (state_q == S_CP_CHK && slot_hit && is_write && !bank_full) begin
					col_req.we = 1'b1;
					col_req.wdata.key = cmd_q.col_key;
					col_req.wdata.val = newval;
					row_req.we = !key_match;
					row_req.addr = row_q;
					row_req.wdata.key = cmd_q.row_key;
					row_req.wdata.cnt = cnt_q + 1'b1;
				end
			end
			S_DP_RD, S_DP_CHK: begin
				col_req.addr = {row_q, cpos_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			rows_q <= '0;
			strobe_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					strobe_q <= 1'b0;
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						rpos_q <= cmd.row_key[ROW_AW-1:0];
						rn_q <= '0;
						if (cmd.pair_limit == '0) begin
							lim_q <= LIM_W'(1);
						end else if (cmd.pair_limit > LIM_W'(MAX_PAIRS)) begin
							lim_q <= LIM_W'(MAX_PAIRS);
						end else begin
							lim_q <= cmd.pair_limit;
						end
						if (cmd.mode > MODE_DUMP) begin
							strobe_q <= 1'b1;
							result_q <= pack_word('0, '0, '0, ST_OK, 1'b1);
						end else begin
							strobe_q <= 1'b0;
							state_q <= S_RP_RD;
						end
					end else begin
						strobe_q <= 1'b0;
					end
				end
				S_RP_RD: begin
					if (used_q[rpos_q]) begin
						strobe_q <= 1'b0;
						state_q <= S_RP_CHK;
					end else if (!is_write || rows_q >= ROWS_W'(ROW_LIM)) begin
						strobe_q <= 1'b1;
						result_q <= pack_word('0, '0, '0,
							is_write ? ST_ROW_FULL : ST_ABSENT, 1'b1);
						state_q <= S_IDLE;
					end else begin
						strobe_q <= 1'b0;
						used_q[rpos_q] <= 1'b1;
						rows_q <= rows_q + 1'b1;
						row_q <= rpos_q;
						cnt_q <= '0;
						cpos_q <= cmd_q.col_key[COL_AW-1:0];
						cn_q <= '0;
						state_q <= S_CP_RD;
					end
				end
				S_RP_CHK: begin
					if (row_hit) begin
						row_q <= rpos_q;
						cnt_q <= row_rdata.cnt;
						cn_q <= '0;
						num_q <= '0;
						pend_v_q <= 1'b0;
						strobe_q <= cmd_q.mode == MODE_CNT;
						result_q <= pack_word('0, '0, 7'(row_rdata.cnt), ST_OK, 1'b1);
						cpos_q <= (cmd_q.mode == MODE_DUMP) ? '0 :
							cmd_q.col_key[COL_AW-1:0];
						if (cmd_q.mode == MODE_CNT) begin
							state_q <= S_IDLE;
						end else if (cmd_q.mode == MODE_DUMP) begin
							state_q <= S_DP_RD;
						end else begin
							state_q <= S_CP_RD;
						end
					end else if (rn_q == ROW_AW'(ROW_SLOTS - 1)) begin
						strobe_q <= 1'b1;
						result_q <= pack_word('0, '0, '0,
							is_write ? ST_ROW_FULL : ST_ABSENT, 1'b1);
						state_q <= S_IDLE;
					end else begin
						strobe_q <= 1'b0;
						rpos_q <= rpos_nx;
						rn_q <= rn_q + 1'b1;
						state_q <= S_RP_RD;
					end
				end
				S_CP_RD: begin
					strobe_q <= 1'b0;
					state_q <= S_CP_CHK;
				end
				S_CP_CHK: begin
					if (slot_hit || cn_q == COL_AW'(COL_SLOTS - 1)) begin
						strobe_q <= 1'b1;
						state_q <= S_IDLE;
						if (is_get) begin
							result_q <= pack_word(slot_hit ? base : 32'd0, '0, '0, ST_OK,
								1'b1);
						end else if (!slot_hit || bank_full) begin
							result_q <= pack_word('0, '0, '0, ST_BANK_FULL, 1'b1);
						end else begin
							result_q <= pack_word(newval, '0, '0, ST_OK, 1'b1);
						end
					end else begin
						strobe_q <= 1'b0;
						cpos_q <= cpos_nx;
						cn_q <= cn_q + 1'b1;
						state_q <= S_CP_RD;
					end
				end
				S_DP_RD: begin
					strobe_q <= 1'b0;
					state_q <= S_DP_CHK;
				end
				S_DP_CHK: begin
					strobe_q <= col_rdata != '0 && pend_v_q;
					result_q <= pack_word(pend_q.val, pend_q.key, '0, ST_OK, 1'b0);
					if (col_rdata != '0) begin
						pend_q <= col_rdata;
						pend_v_q <= 1'b1;
						num_q <= num_nx;
					end
					if ((col_rdata != '0 && num_nx >= lim_q) ||
						cpos_q == COL_AW'(COL_SLOTS - 1)) begin
						state_q <= S_FLUSH;
					end else begin
						cpos_q <= cpos_nx;
						state_q <= S_DP_RD;
					end
				end
				S_FLUSH: begin
					strobe_q <= 1'b1;
					if (pend_v_q) begin
						result_q <= pack_word(pend_q.val, pend_q.key, '0, ST_OK, 1'b1);
					end else begin
						result_q <= pack_word('0, '0, '0, ST_ABSENT, 1'b1);
					end
					pend_v_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					strobe_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign strobe = strobe_q;
	assign result = result_q;

	`SMHS_NEVER(a_no_word_in_clear, strobe_q && state_q == S_CLEAR)
	`SMHS_NEVER(a_row_limit, rows_q > ROWS_W'(ROW_LIM))
	`SMHS_ASSERT(a_idle_after_last,
		$fell(busy) && $past(state_q) != S_CLEAR |-> strobe_q && result_q.last)
	`SMHS_NEVER(a_accept_mid_dump, start && !busy && strobe_q && !result_q.last)
endmodule
`default_nettype wire

>>> hdl/sparse_matrix_hash_store.sv
// Sparse matrix store on two levels of linear-probing hash tables. After reset the
// column memory is swept clear, one entry a cycle, with busy high. A command is
// taken when start is high and busy low; each result word is shown for one cycle
// with strobe and cannot be held off. Both memories are single port with a registered
// read, which sets the pace: each row slot probed passes a read state and a check state
// (S_RP_RD, S_RP_CHK), as does each column slot (S_CP_RD, S_CP_CHK); a dump reads the
// bank in slot order through S_DP_RD and S_DP_CHK up to its pair limit, then S_FLUSH.
// depends on smhs_pkg, smhs_ram and smhs_ctrl
`default_nettype none
module sparse_matrix_hash_store import smhs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire cmd_t cmd,
	output logic busy,
	output logic strobe,
	output result_t result
);
	row_req_t row_req;
	col_req_t col_req;
	row_word_t row_rdata;
	col_word_t col_rdata;

	smhs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result),
		.row_req(row_req),
		.row_rdata(row_rdata),
		.col_req(col_req),
		.col_rdata(col_rdata)
	);

	smhs_ram #(.WIDTH($bits(row_word_t)), .DEPTH(ROW_SLOTS)) u_row_ram (
		.clk(clk),
		.we(row_req.we),
		.addr(row_req.addr),
		.wdata(row_req.wdata),
		.rdata(row_rdata)
	);

	smhs_ram #(.WIDTH($bits(col_word_t)), .DEPTH(MEM_DEPTH)) u_col_ram (
		.clk(clk),
		.we(col_req.we),
		.addr(col_req.addr),
		.wdata(col_req.wdata),
		.rdata(col_rdata)
	);
endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking bench for sparse_matrix_hash_store: directed then random command words,
// every result word checked against an in-bench model of the two-level hash tables
// depends on smhs_pkg and the sparse_matrix_hash_store rtl
`default_nettype none
module testbench;
	import smhs_pkg::*;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam int N_RANDOM = 308;
	localparam int IDLE_LIMIT = 20000;

	class hash_store_scoreboard;
		logic [31:0] row_key_tab [ROW_SLOTS];
		bit row_used [ROW_SLOTS];
		int row_cnt [ROW_SLOTS];
		int rows_used;
		logic [63:0] cells [MEM_DEPTH];
		result_t expected_words [$];
		int errors;
		int words_seen;
		int dumps;
		int full_hits;

		function new();
			for (int i = 0; i < ROW_SLOTS; i++) begin
				row_key_tab[i] = '0;
				row_used[i] = 0;
				row_cnt[i] = 0;
			end
			for (int i = 0; i < MEM_DEPTH; i++)
				cells[i] = '0;
			rows_used = 0;
			errors = 0;
			words_seen = 0;
			dumps = 0;
			full_hits = 0;
		endfunction

		function void push(logic [31:0] v, logic [31:0] k, logic [6:0] n, logic [1:0] st,
			logic lst);
			result_t r;
			r.result_value = v;
			r.result_key = k;
			r.entry_count = n;
			r.status = st;
			r.last = lst;
			expected_words.push_back(r);
		endfunction

		function int col_slot(int row, logic [31:0] key);
			int p;
			p = key % COL_SLOTS;
			for (int n = 0; n < COL_SLOTS; n++) begin
				if (cells[row*COL_SLOTS+p][63:32] == key || cells[row*COL_SLOTS+p] == 64'd0)
					return p;
				p = (p + 1) % COL_SLOTS;
			end
			return COL_SLOTS;
		endfunction

		function void note(cmd_t c);
			int row;
			int p;
			int cs;
			int idx;
			int lim;
			int num;
			bit hit;
			logic [31:0] v;
			hit = 0;
			row = ROW_SLOTS;
			p = c.row_key % ROW_SLOTS;
			for (int n = 0; n < ROW_SLOTS; n++) begin
				if (!row_used[p]) begin
					row = p;
					break;
				end
				if (row_key_tab[p] == c.row_key) begin
					row = p;
					hit = 1;
					break;
				end
				p = (p + 1) % ROW_SLOTS;
			end
			if (c.mode == MODE_SPARE_A || c.mode == MODE_SPARE_B) begin
				push(0, 0, 0, ST_OK, 1);
				return;
			end
			if (c.mode == MODE_GET || c.mode == MODE_CNT || c.mode == MODE_DUMP) begin
				if (!hit) begin
					push(0, 0, 0, ST_ABSENT, 1);
					return;
				end
				if (c.mode == MODE_GET) begin
					cs = col_slot(row, c.col_key);
					v = 0;
					if (cs < COL_SLOTS && cells[row*COL_SLOTS+cs][63:32] == c.col_key)
						v = cells[row*COL_SLOTS+cs][31:0];
					push(v, 0, 0, ST_OK, 1);
				end else if (c.mode == MODE_CNT) begin
					push(0, 0, 7'(row_cnt[row]), ST_OK, 1);
				end else begin
					dumps++;
					lim = int'(c.pair_limit);
					if (lim == 0)
						lim = 1;
					if (lim > MAX_PAIRS)
						lim = MAX_PAIRS;
					num = 0;
					for (int s = 0; s < COL_SLOTS && num < lim; s++) begin
						if (cells[row*COL_SLOTS+s] != 64'd0) begin
							push(cells[row*COL_SLOTS+s][31:0], cells[row*COL_SLOTS+s][63:32],
								0, ST_OK, 0);
							num++;
						end
					end
					if (num == 0)
						push(0, 0, 0, ST_ABSENT, 1);
					else
						expected_words[$].last = 1;
				end
				return;
			end
			if (!hit) begin
				if (row >= ROW_SLOTS || rows_used * 4 >= ROW_SLOTS * 3) begin
					full_hits++;
					push(0, 0, 0, ST_ROW_FULL, 1);
					return;
				end
				row_used[row] = 1;
				row_key_tab[row] = c.row_key;
				row_cnt[row] = 0;
				rows_used++;
			end
			cs = col_slot(row, c.col_key);
			if (cs >= COL_SLOTS) begin
				full_hits++;
				push(0, 0, 0, ST_BANK_FULL, 1);
				return;
			end
			idx = row * COL_SLOTS + cs;
			if (cells[idx][63:32] != c.col_key) begin
				if (row_cnt[row] > COL_SLOTS / 2) begin
					full_hits++;
					push(0, 0, 0, ST_BANK_FULL, 1);
					return;
				end
				row_cnt[row]++;
				cells[idx] = {c.col_key, 32'd0};
			end
			v = cells[idx][31:0];
			if (c.mode == MODE_SET)
				v = c.operand;
			else if (c.mode == MODE_ADD)
				v = v + c.operand;
			else
				v = v - c.operand;
			cells[idx] = {c.col_key, v};
			push(v, 0, 0, ST_OK, 1);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("word %0d: %s is %h, expected %h", words_seen, field, got, want);
		endtask

		task check(result_t r);
			result_t e;
			words_seen++;
			if (expected_words.size() == 0) begin
				report("unexpected word", r.result_value, 32'd0);
				return;
			end
			e = expected_words.pop_front();
			if (r.result_value !== e.result_value)
				report("result_value", r.result_value, e.result_value);
			if (r.result_key !== e.result_key)
				report("result_key", r.result_key, e.result_key);
			if (r.entry_count !== e.entry_count)
				report("entry_count", 32'(r.entry_count), 32'(e.entry_count));
			if (r.status !== e.status)
				report("status", 32'(r.status), 32'(e.status));
			if (r.last !== e.last)
				report("last", 32'(r.last), 32'(e.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic strobe;
	result_t result;

	hash_store_scoreboard sb = new();
	logic [31:0] row_pool [60];
	logic [31:0] col_pool [48];
	int idle_cycles = 0;
	int items_sent = 0;

	sparse_matrix_hash_store DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note(cmd);
		if (arst_n && strobe)
			sb.check(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("sparse_matrix_hash_store: mismatch");
			$finish;
		end
	end

	function cmd_t make_cmd(logic [2:0] m, logic [31:0] rk, logic [31:0] ck,
		logic [31:0] op, logic [6:0] lim);
		cmd_t c;
		c.mode = m;
		c.row_key = rk;
		c.col_key = ck;
		c.operand = op;
		c.pair_limit = lim;
		return c;
	endfunction

	function cmd_t random_cmd();
		int pick;
		logic [2:0] m;
		logic [31:0] rk;
		logic [31:0] ck;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			m = MODE_GET;
		else if (pick < 40)
			m = MODE_SET;
		else if (pick < 58)
			m = MODE_ADD;
		else if (pick < 74)
			m = MODE_SUB;
		else if (pick < 84)
			m = MODE_CNT;
		else if (pick < 96)
			m = MODE_DUMP;
		else
			m = 3'($urandom_range(6, 7));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			rk = row_pool[$urandom_range(0, 3)];
		else if (pick < 92)
			rk = row_pool[$urandom_range(0, 59)];
		else
			rk = $urandom;
		ck = ($urandom_range(0, 9) == 0) ? $urandom : col_pool[$urandom_range(0, 47)];
		return make_cmd(m, rk, ck, $urandom,
			7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8)));
	endfunction

	task send(cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	function int draw_gap();
		return ((items_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 10);
	endfunction

	initial begin
		logic [31:0] rk;
		for (int i = 0; i < 60; i++)
			row_pool[i] = ($urandom & ~32'h3f) | (i % 40);
		row_pool[5] = 32'd0;
		row_pool[6] = 32'hffff_ffff;
		for (int i = 0; i < 48; i++)
			col_pool[i] = ($urandom & ~32'h3f) | (i % 30);
		col_pool[0] = 32'd0;
		col_pool[1] = 32'hffff_ffff;
		rk = row_pool[0];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed words
		send(make_cmd(MODE_GET, rk, 5, 0, 1), draw_gap());
		send(make_cmd(MODE_CNT, rk, 0, 0, 1), draw_gap());
		send(make_cmd(MODE_DUMP, rk, 0, 0, 1), draw_gap());
		send(make_cmd(MODE_SET, rk, 32'hffff_ffff, 32'hffff_ffff, 0), draw_gap());
		send(make_cmd(MODE_ADD, rk, 32'hffff_ffff, 1, 0), draw_gap());
		send(make_cmd(MODE_SUB, rk, 32'h40, 1, 0), draw_gap());
		send(make_cmd(MODE_GET, rk, 32'h1234, 0, 0), draw_gap());
		send(make_cmd(MODE_SET, rk, 0, 32'h8000_0001, 0), draw_gap());
		send(make_cmd(MODE_SUB, rk, 0, 32'h8000_0001, 0), draw_gap());
		send(make_cmd(MODE_GET, rk, 0, 0, 0), draw_gap());
		send(make_cmd(MODE_ADD, rk, 0, 7, 0), draw_gap());
		send(make_cmd(MODE_CNT, rk, 0, 0, 0), draw_gap());
		send(make_cmd(MODE_DUMP, rk, 0, 0, 7'd0), draw_gap());
		send(make_cmd(MODE_DUMP, rk, 0, 0, 7'd1), draw_gap());
		send(make_cmd(MODE_DUMP, rk, 0, 0, 7'd127), draw_gap());
		send(make_cmd(MODE_SET, 32'hffff_ffff, 0, 0, 0), draw_gap());
		send(make_cmd(MODE_DUMP, 32'hffff_ffff, 0, 0, 7'd64), draw_gap());
		send(make_cmd(MODE_SET, 32'd0, 32'h7fff_ffff, 32'h5555_aaaa, 0), draw_gap());
		send(make_cmd(MODE_SET, 32'h40, 32'h80, 32'haaaa_5555, 0), draw_gap());
		send(make_cmd(MODE_GET, 32'h40, 32'h80, 0, 0), draw_gap());
		send(make_cmd(MODE_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 7'h7f),
			draw_gap());
		send(make_cmd(MODE_SPARE_B, rk, 1, 1, 1), draw_gap());

		// row bank pressure on one row, then random traffic
		for (int i = 0; i < 40; i++)
			send(make_cmd(MODE_SET, row_pool[1], col_pool[i], $urandom, 0), draw_gap());
		for (int i = 0; i < N_RANDOM; i++)
			send(random_cmd(), draw_gap());
		start <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d command words sent, %0d result words checked", items_sent,
			sb.words_seen);
		$display("%0d row dumps, %0d full-table answers", sb.dumps, sb.full_hits);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("sparse_matrix_hash_store: match");
		else
			$display("sparse_matrix_hash_store: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/smhs_pkg.sv
hdl/smhs_ram.sv
hdl/smhs_ctrl.sv
hdl/sparse_matrix_hash_store.sv
tb/testbench.sv
